>>> hw/rtl/urlsp_pkg.sv
// shared types, constants and the scheme name lookup for the url splitter
// no dependencies

package urlsp_pkg;

  localparam int unsigned MaxLenDefault = 256;
  localparam int unsigned NumSchemes    = 7;

  // status codes
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusNoSep    = 3'd1;
  localparam logic [2:0] StatusBadSch   = 3'd2;
  localparam logic [2:0] StatusNoPath   = 3'd3;
  localparam logic [2:0] StatusBadHost  = 3'd4;
  localparam logic [2:0] StatusTooLong  = 3'd5;

  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CharDot   = 8'h2e;

  // one accepted byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } urlsp_beat_t;

  // one result beat
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] scheme_id;
    logic [7:0] host_start;
    logic [7:0] tld_start;
    logic [7:0] path_start;
    logic [8:0] url_length;
  } urlsp_res_t;

  // length of each scheme name
  function automatic logic [2:0] scheme_len(input int unsigned k);
    logic [2:0] len;
    unique case (k)
      0: len = 3'd4;  // http
      1: len = 3'd5;  // https
      2: len = 3'd3;  // ftp
      3: len = 3'd6;  // mailto
      4: len = 3'd4;  // file
      5: len = 3'd4;  // news
      6: len = 3'd6;  // telnet
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // byte idx of scheme name k, zero past its end
  function automatic logic [7:0] scheme_char(input int unsigned k, input logic [2:0] idx);
    logic [47:0] name;
    logic [7:0]  ch;
    unique case (k)
      0: name = {"http",   16'h0};
      1: name = {"https",   8'h0};
      2: name = {"ftp",    24'h0};
      3: name = "mailto";
      4: name = {"file",   16'h0};
      5: name = {"news",   16'h0};
      6: name = "telnet";
      default: name = 48'h0;
    endcase
    unique case (idx)
      3'd0: ch = name[47:40];
      3'd1: ch = name[39:32];
      3'd2: ch = name[31:24];
      3'd3: ch = name[23:16];
      3'd4: ch = name[15:8];
      3'd5: ch = name[7:0];
      default: ch = 8'h0;
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/urlsp_in_reg.sv
// input register: holds one accepted byte until the parser consumes it
// depends on urlsp_pkg

module urlsp_in_reg
  import urlsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        last_char_i,
  input  logic        consume_i,
  output urlsp_beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic       accept;

  assign in_stall_o = valid_q && !consume_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= char_in_i;
      last_q <= last_char_i;
    end
  end

  assign beat_o = '{valid: valid_q, ch: ch_q, last: last_q};

endmodule

>>> hw/rtl/urlsp_parse.sv
// parse state machine: updates scheme, host and path tracking per byte
// and forms the result on the last byte; depends on urlsp_pkg

module urlsp_parse
  import urlsp_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  urlsp_beat_t beat_i,
  input  logic        en_i,
  output urlsp_res_t  res_o
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    PhScheme,
    PhSlash1,
    PhSlash2,
    PhHost,
    PhPath,
    PhErr
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [NumSchemes-1:0] match_q, match_d;
  logic [PosW-1:0]     host_q, host_d;
  logic [PosW-1:0]     dot_q, dot_d;
  logic [1:0]          dots_q, dots_d;
  logic [PosW-1:0]     path_q, path_d;
  logic [2:0]          err_q, err_d;
  logic                lead_q, lead_d;

  logic [2:0]          status;
  logic [2:0]          sid;
  logic [7:0]          c;

  assign c = beat_i.ch;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    match_d = match_q;
    host_d  = host_q;
    dot_d   = dot_q;
    dots_d  = dots_q;
    path_d  = path_q;
    err_d   = err_q;
    lead_d  = lead_q;

    if (pos_q >= PosW'(MAX_LEN)) begin
      err_d   = StatusTooLong;
      phase_d = PhErr;
    end else begin
      unique case (phase_q)
        PhScheme: begin
          for (int unsigned k = 0; k < NumSchemes; k++) begin
            if (c == CharColon) begin
              if (pos_q != PosW'(scheme_len(k))) match_d[k] = 1'b0;
            end else if (!((pos_q < PosW'(scheme_len(k))) &&
                           (scheme_char(k, pos_q[2:0]) == c))) begin
              match_d[k] = 1'b0;
            end
          end
          if (c == CharColon) phase_d = PhSlash1;
        end
        PhSlash1: begin
          if (c == CharSlash) begin
            phase_d = PhSlash2;
          end else begin
            err_d   = StatusNoSep;
            phase_d = PhErr;
          end
        end
        PhSlash2: begin
          if (c != CharSlash) begin
            err_d   = StatusNoSep;
            phase_d = PhErr;
          end else if (match_q == '0) begin
            err_d   = StatusBadSch;
            phase_d = PhErr;
          end else begin
            host_d  = pos_q + PosW'(1);
            phase_d = PhHost;
          end
        end
        PhHost: begin
          if (c == CharSlash) begin
            path_d  = pos_q;
            phase_d = PhPath;
          end else if (c == CharDot) begin
            if (pos_q == host_q) lead_d = 1'b1;
            dot_d = pos_q;
            if (dots_q != 2'd2) dots_d = dots_q + 2'd1;
          end
        end
        default: ;
      endcase
      pos_d = pos_q + PosW'(1);
    end
  end

  // status from the updated state
  always_comb begin
    priority if (err_d != StatusOk) begin
      status = err_d;
    end else if (phase_d == PhScheme || phase_d == PhSlash1 || phase_d == PhSlash2) begin
      status = StatusNoSep;
    end else if (phase_d == PhHost) begin
      status = StatusNoPath;
    end else if (!lead_d && (dots_d == 2'd2 ||
                 (dots_d == 2'd1 && (dot_d + PosW'(1)) != path_d))) begin
      status = StatusOk;
    end else begin
      status = StatusBadHost;
    end
  end

  // lowest surviving scheme candidate
  always_comb begin
    sid = '0;
    for (int k = NumSchemes - 1; k >= 0; k--) begin
      if (match_d[k]) sid = 3'(k);
    end
  end

  always_comb begin
    res_o.status     = status;
    res_o.url_length = 9'(pos_d);
    if (status == StatusOk) begin
      res_o.scheme_id  = sid;
      res_o.host_start = 8'(host_d);
      res_o.tld_start  = 8'(dot_d);
      res_o.path_start = 8'(path_d);
    end else begin
      res_o.scheme_id  = '0;
      res_o.host_start = '0;
      res_o.tld_start  = '0;
      res_o.path_start = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhScheme;
      pos_q   <= '0;
      match_q <= '1;
      host_q  <= '0;
      dot_q   <= '0;
      dots_q  <= '0;
      path_q  <= '0;
      err_q   <= StatusOk;
      lead_q  <= 1'b0;
    end else if (en_i) begin
      if (beat_i.last) begin
        // back to the start for the next url
        phase_q <= PhScheme;
        pos_q   <= '0;
        match_q <= '1;
        host_q  <= '0;
        dot_q   <= '0;
        dots_q  <= '0;
        path_q  <= '0;
        err_q   <= StatusOk;
        lead_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        match_q <= match_d;
        host_q  <= host_d;
        dot_q   <= dot_d;
        dots_q  <= dots_d;
        path_q  <= path_d;
        err_q   <= err_d;
        lead_q  <= lead_d;
      end
    end
  end

endmodule

>>> hw/rtl/urlsp_out_reg.sv
// result register: holds one result beat until the consumer takes it
// depends on urlsp_pkg

module urlsp_out_reg
  import urlsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  urlsp_res_t res_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output urlsp_res_t res_o
);

  logic       valid_q, valid_d;
  urlsp_res_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/url_splitter_unit.sv
// top level of the url splitter: input register, parser, result register
// depends on urlsp_pkg, urlsp_in_reg, urlsp_parse, urlsp_out_reg

// The unit takes a url one byte per beat, with last_char_i marking the final
// byte, and returns one result beat per url: status, scheme id, host start,
// offset of the last host dot, path start and byte count. Each byte is held in
// the input register and is folded into the parse state when it leaves it, so
// bytes stream at one per cycle unless a last byte waits on a held result; the
// result register loads at the same edge that folds in the last byte.
// A held result stalls the input only when the next byte waiting is
// itself a last byte; other bytes keep flowing. Urls longer than MAX_LEN bytes
// report status 5 with url_length saturated at MAX_LEN (masked to 9 bits).

module url_splitter_unit
  import urlsp_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte stream in
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       last_char_i,
  // result beat out
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [2:0] scheme_id_o,
  output logic [7:0] host_start_o,
  output logic [7:0] tld_start_o,
  output logic [7:0] path_start_o,
  output logic [8:0] url_length_o
);

  urlsp_beat_t beat;
  urlsp_res_t  res_comb;
  urlsp_res_t  res_out;
  logic        consume;
  logic        load;

  // a byte in the input register moves on unless it would produce a result
  // while the result register is full and stalled
  assign consume = beat.valid && (!beat.last || !out_valid_o || !out_stall_i);
  assign load    = consume && beat.last;

  urlsp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_in_i   (char_in_i),
    .last_char_i (last_char_i),
    .consume_i   (consume),
    .beat_o      (beat)
  );

  urlsp_parse #(
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .en_i   (consume),
    .res_o  (res_comb)
  );

  urlsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res_comb),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign status_o     = res_out.status;
  assign scheme_id_o  = res_out.scheme_id;
  assign host_start_o = res_out.host_start;
  assign tld_start_o  = res_out.tld_start;
  assign path_start_o = res_out.path_start;
  assign url_length_o = res_out.url_length;

endmodule
